FILE: src/udp_ipv4_header_generator_top_macros.svh
// Assertion helpers for the RTL of the header generator.
`ifndef UDP_IPV4_HEADER_GENERATOR_TOP_MACROS_SVH
`define UDP_IPV4_HEADER_GENERATOR_TOP_MACROS_SVH

// Same-cycle implication, checked outside of reset.
`define UIHG_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked outside of reset.
`define UIHG_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);

`endif

FILE: src/uihg_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package uihg_pkg;

  localparam int unsigned MAX_PAYLOAD_DEF = 1472;
  localparam int unsigned QUEUE_DEPTH_DEF = 4;

  // Width of the IPv4 and UDP length fields.
  localparam int unsigned LEN_W = 16;

  localparam logic [LEN_W-1:0] UDP_HDR_BYTES    = 16'd8;
  localparam logic [LEN_W-1:0] IP_UDP_HDR_BYTES = 16'd28;

  localparam logic [15:0] ETHERTYPE_IPV4 = 16'h0800;
  localparam logic [7:0]  IP_VER_IHL     = 8'h45;
  localparam logic [7:0]  IP_TOS         = 8'h00;
  localparam logic [15:0] IP_ID          = 16'haabb;
  localparam logic [15:0] IP_FRAG        = 16'h0000;
  localparam logic [7:0]  IP_TTL         = 8'h80;
  localparam logic [7:0]  IP_PROTO_UDP   = 8'h11;
  // Folded sum of the fixed IPv4 header words: 0x4500 + 0xaabb + 0x8011.
  localparam logic [15:0] IP_FIXED_SUM   = 16'h6fcd;

  localparam logic [15:0] DEST_PORT_RST  = 16'd53;

  // Configuration register indexes.
  localparam logic [2:0] REG_SOURCE_MAC  = 3'd0;
  localparam logic [2:0] REG_DEST_MAC    = 3'd1;
  localparam logic [2:0] REG_SOURCE_IP   = 3'd2;
  localparam logic [2:0] REG_DEST_IP     = 3'd3;
  localparam logic [2:0] REG_SOURCE_PORT = 3'd4;
  localparam logic [2:0] REG_DEST_PORT   = 3'd5;

  localparam logic [3:0] VB_FULL = 4'd8;
  localparam logic [3:0] VB_LAST = 4'd2;

  typedef struct packed {
    logic [47:0] source_mac;
    logic [47:0] dest_mac;
    logic [31:0] source_ip;
    logic [31:0] dest_ip;
    logic [15:0] source_port;
    logic [15:0] dest_port;
  } cfg_t;

  // One finished datagram as handed from the front to the back.
  typedef struct packed {
    logic             too_long;
    logic [LEN_W-1:0] len;
    logic [15:0]      psum;
    logic [15:0]      pad;
  } desc_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  // Ones' complement sum of three 16-bit words with end-around carry.
  function automatic logic [15:0] oc_add3(input logic [15:0] a, input logic [15:0] b,
                                          input logic [15:0] c);
    logic [17:0] s;
    logic [16:0] t;
    s = {2'b00, a} + {2'b00, b} + {2'b00, c};
    t = {1'b0, s[15:0]} + {15'd0, s[17:16]};
    return t[15:0] + {15'd0, t[16]};
  endfunction

endpackage

`default_nettype wire

FILE: src/uihg_front.sv
`timescale 1ns / 1ps
`default_nettype none

module uihg_front #(
  parameter int unsigned MAX_PAYLOAD = uihg_pkg::MAX_PAYLOAD_DEF
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               s_axis_tvalid,
  output logic                    s_axis_tready,
  input  wire logic [7:0]         s_axis_tdata,  // [7:0] payload_byte
  input  wire logic               s_axis_tlast,  // last_byte
  input  wire uihg_pkg::q_status_t q_status_i,
  output logic                    push_o,
  output uihg_pkg::desc_t         desc_o
);

  localparam int unsigned CNT_W = $clog2(MAX_PAYLOAD + 1);
  localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_PAYLOAD);

  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [15:0]      sum_q, sum_d;
  logic [7:0]       held_q, held_d;
  logic             odd_q, odd_d;
  logic             ovf_q, ovf_d;
  logic             accept;
  logic             at_max;

  assign s_axis_tready = !q_status_i.full;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign at_max        = (cnt_q == MAX_CNT);

  always_comb begin
    cnt_d  = cnt_q;
    sum_d  = sum_q;
    held_d = held_q;
    odd_d  = odd_q;
    ovf_d  = ovf_q | at_max;
    if (!at_max) begin
      cnt_d = cnt_q + CNT_W'(1);
      if (odd_q) begin
        sum_d  = uihg_pkg::oc_add3(sum_q, {held_q, s_axis_tdata}, 16'h0000);
        held_d = 8'h00;
        odd_d  = 1'b0;
      end else begin
        held_d = s_axis_tdata;
        odd_d  = 1'b1;
      end
    end
  end

  assign push_o          = accept && s_axis_tlast;
  assign desc_o.too_long = ovf_d;
  assign desc_o.len      = uihg_pkg::LEN_W'(cnt_d);
  assign desc_o.psum     = sum_d;
  // An odd byte left over is the high half of a zero-padded word.
  assign desc_o.pad      = odd_d ? {held_d, 8'h00} : 16'h0000;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      sum_q  <= '0;
      held_q <= '0;
      odd_q  <= 1'b0;
      ovf_q  <= 1'b0;
    end else if (accept) begin
      if (s_axis_tlast) begin
        cnt_q  <= '0;
        sum_q  <= '0;
        held_q <= '0;
        odd_q  <= 1'b0;
        ovf_q  <= 1'b0;
      end else begin
        cnt_q  <= cnt_d;
        sum_q  <= sum_d;
        held_q <= held_d;
        odd_q  <= odd_d;
        ovf_q  <= ovf_d;
      end
    end
  end

endmodule

`default_nettype wire

FILE: src/uihg_queue.sv
`timescale 1ns / 1ps
`default_nettype none

module uihg_queue #(
  parameter int unsigned DEPTH = uihg_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 push_i,
  input  wire uihg_pkg::desc_t      push_data_i,
  input  wire logic                 pop_i,
  output uihg_pkg::desc_t           pop_data_o,
  output uihg_pkg::q_status_t       status_o
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  uihg_pkg::desc_t  mem_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [CNT_W-1:0] cnt_q;
  logic             do_push, do_pop;

  assign status_o.full  = (cnt_q == FULL_CNT);
  assign status_o.empty = (cnt_q == '0);
  assign do_push        = push_i && !status_o.full;
  assign do_pop         = pop_i && !status_o.empty;
  assign pop_data_o     = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + CNT_W'(1);
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - CNT_W'(1);
      end
    end
  end

endmodule

`default_nettype wire

FILE: src/uihg_back.sv
`timescale 1ns / 1ps
`default_nettype none

module uihg_back (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire uihg_pkg::cfg_t      cfg_i,
  input  wire uihg_pkg::q_status_t q_status_i,
  input  wire uihg_pkg::desc_t     q_data_i,
  output logic                     q_pop_o,
  output logic                     m_axis_tvalid,
  input  wire logic                m_axis_tready,
  output logic [71:0]              m_axis_tdata,  // [63:0] header_word, [67:64] valid_bytes
  output logic                     m_axis_tlast,  // last_word
  output logic                     m_axis_tuser   // too_long
);

  // Word selects, in wire order.
  localparam logic [2:0] WORD_MACS   = 3'd0;
  localparam logic [2:0] WORD_ETH_IP = 3'd1;
  localparam logic [2:0] WORD_IP_LEN = 3'd2;
  localparam logic [2:0] WORD_IP_CK  = 3'd3;
  localparam logic [2:0] WORD_UDP    = 3'd4;
  localparam logic [2:0] WORD_UDP_CK = 3'd5;

  // Checksum steps; each folds two more terms into the UDP sum, up to two into the IPv4 sum.
  localparam logic [2:0] STEP_INIT     = 3'd0;
  localparam logic [2:0] STEP_ADDR     = 3'd1;
  localparam logic [2:0] STEP_PROTO    = 3'd2;
  localparam logic [2:0] STEP_LEN_PORT = 3'd3;
  localparam logic [2:0] STEP_PORT_LEN = 3'd4;
  localparam logic [2:0] IP_DONE       = 3'd3;
  localparam logic [2:0] UDP_DONE      = 3'd5;

  logic        busy_q;
  logic [2:0]  wsel_q, step_q;
  logic        ovf_q;
  logic [15:0] udplen_q, totlen_q, psum_q, pad_q;
  logic [15:0] usum_q, usum_d, isum_q, isum_d;
  logic [15:0] u_base, u_a, u_b, i_base, i_a, i_b;
  logic        tvalid_q, tlast_q, tuser_q;
  logic [63:0] word_q, word_d;
  logic [3:0]  vb_q, vb_d;
  logic        out_free, word_ok, emit, done, stepping;

  assign out_free = !tvalid_q || m_axis_tready;
  assign word_ok  = !((wsel_q == WORD_IP_CK && step_q < IP_DONE) ||
                      (wsel_q == WORD_UDP_CK && step_q < UDP_DONE));
  assign emit     = busy_q && word_ok && out_free;
  assign done     = emit && (wsel_q == WORD_UDP_CK);
  assign q_pop_o  = !q_status_i.empty && (!busy_q || done);
  assign stepping = busy_q && (step_q < UDP_DONE);

  always_comb begin
    u_base = usum_q;
    u_a    = 16'h0000;
    u_b    = 16'h0000;
    i_base = isum_q;
    i_a    = 16'h0000;
    i_b    = 16'h0000;
    case (step_q)
      STEP_INIT: begin
        u_base = psum_q;
        u_a    = pad_q;
        u_b    = cfg_i.source_ip[31:16];
        i_base = uihg_pkg::IP_FIXED_SUM;
        i_a    = totlen_q;
        i_b    = cfg_i.source_ip[31:16];
      end
      STEP_ADDR: begin
        u_a = cfg_i.source_ip[15:0];
        u_b = cfg_i.dest_ip[31:16];
        i_a = cfg_i.source_ip[15:0];
        i_b = cfg_i.dest_ip[31:16];
      end
      STEP_PROTO: begin
        u_a = cfg_i.dest_ip[15:0];
        u_b = {8'h00, uihg_pkg::IP_PROTO_UDP};
        i_a = cfg_i.dest_ip[15:0];
      end
      STEP_LEN_PORT: begin
        u_a = udplen_q;
        u_b = cfg_i.source_port;
      end
      STEP_PORT_LEN: begin
        u_a = cfg_i.dest_port;
        u_b = udplen_q;
      end
      default: begin
      end
    endcase
    usum_d = uihg_pkg::oc_add3(u_base, u_a, u_b);
    isum_d = uihg_pkg::oc_add3(i_base, i_a, i_b);
  end

  always_comb begin
    word_d = 64'h0;
    vb_d   = uihg_pkg::VB_FULL;
    case (wsel_q)
      WORD_MACS:   word_d = {cfg_i.dest_mac, cfg_i.source_mac[47:32]};
      WORD_ETH_IP: word_d = {cfg_i.source_mac[31:0], uihg_pkg::ETHERTYPE_IPV4,
                             uihg_pkg::IP_VER_IHL, uihg_pkg::IP_TOS};
      WORD_IP_LEN: word_d = {totlen_q, uihg_pkg::IP_ID, uihg_pkg::IP_FRAG,
                             uihg_pkg::IP_TTL, uihg_pkg::IP_PROTO_UDP};
      WORD_IP_CK:  word_d = {~isum_q, cfg_i.source_ip, cfg_i.dest_ip[31:16]};
      WORD_UDP:    word_d = {cfg_i.dest_ip[15:0], cfg_i.source_port, cfg_i.dest_port,
                             udplen_q};
      WORD_UDP_CK: begin
        word_d = {~usum_q, 48'h0};
        vb_d   = uihg_pkg::VB_LAST;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q   <= 1'b0;
      wsel_q   <= '0;
      step_q   <= '0;
      tvalid_q <= 1'b0;
    end else begin
      if (q_pop_o) begin
        busy_q <= 1'b1;
        wsel_q <= WORD_MACS;
        step_q <= STEP_INIT;
      end else begin
        if (done) begin
          busy_q <= 1'b0;
        end else if (emit) begin
          wsel_q <= wsel_q + 3'd1;
        end
        if (stepping) begin
          step_q <= step_q + 3'd1;
        end
      end
      if (emit) begin
        tvalid_q <= 1'b1;
      end else if (m_axis_tready) begin
        tvalid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      ovf_q    <= q_data_i.too_long;
      udplen_q <= q_data_i.len + uihg_pkg::UDP_HDR_BYTES;
      totlen_q <= q_data_i.len + uihg_pkg::IP_UDP_HDR_BYTES;
      psum_q   <= q_data_i.psum;
      pad_q    <= q_data_i.pad;
    end
    if (stepping && !q_pop_o) begin
      usum_q <= usum_d;
      if (step_q < IP_DONE) begin
        isum_q <= isum_d;
      end
    end
    if (emit) begin
      word_q  <= word_d;
      vb_q    <= vb_d;
      tlast_q <= (wsel_q == WORD_UDP_CK);
      tuser_q <= ovf_q;
    end
  end

  assign m_axis_tvalid = tvalid_q;
  assign m_axis_tdata  = {4'h0, vb_q, word_q};
  assign m_axis_tlast  = tlast_q;
  assign m_axis_tuser  = tuser_q;

endmodule

`default_nettype wire

FILE: src/udp_ipv4_header_generator_top.sv
// Ethernet / IPv4 / UDP header generator.
// Payload bytes enter on the s_axis channel, one byte per cycle, with tlast on
// the final byte of a datagram. The payload itself is not kept; only a byte
// count and a ones' complement sum run along. Bytes beyond MAX_PAYLOAD are
// dropped and the datagram's header words carry tuser high.
// After the last byte is taken and queued, the 42-byte header starts to leave on
// m_axis as six 64-bit words, first wire byte in bits 63..56 and the valid
// byte count in bits 67..64; tlast marks the sixth word, which holds two bytes.
// The back end builds one header at a time and pops the next as its last word goes;
// the UDP checksum finishes in five steps of a three-input adder and the IPv4
// checksum in three, while the first words go out. A four-entry queue of
// finished datagrams sits between the byte counter and the sequencer, so
// s_axis_tready drops only when four datagrams wait behind the header being
// sent. A stall on m_axis holds the output word in place.
// Configuration registers are written through cfg_valid_i / cfg_index_i /
// cfg_data_i; the user must do so between datagrams, while no header is pending,
// as the block does not check it. cfg_ready_o is always high. Reset clears the
// count, sum and queue and zeroes all registers except the destination port (53).
`timescale 1ns / 1ps
`default_nettype none

`include "udp_ipv4_header_generator_top_macros.svh"

module udp_ipv4_header_generator_top #(
  parameter int unsigned MAX_PAYLOAD = uihg_pkg::MAX_PAYLOAD_DEF,
  parameter int unsigned QUEUE_DEPTH = uihg_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,  // [7:0] payload_byte
  input  wire logic        s_axis_tlast,  // last_byte
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [71:0]      m_axis_tdata,  // [63:0] header_word, [67:64] valid_bytes
  output logic             m_axis_tlast,  // last_word
  output logic             m_axis_tuser,  // too_long
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [2:0]  cfg_index_i,
  input  wire logic [47:0] cfg_data_i
);

  uihg_pkg::cfg_t      cfg_q;
  uihg_pkg::desc_t     push_desc, pop_desc;
  uihg_pkg::q_status_t q_status;
  logic                q_push, q_pop;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.source_mac  <= '0;
      cfg_q.dest_mac    <= '0;
      cfg_q.source_ip   <= '0;
      cfg_q.dest_ip     <= '0;
      cfg_q.source_port <= '0;
      cfg_q.dest_port   <= uihg_pkg::DEST_PORT_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        uihg_pkg::REG_SOURCE_MAC:  cfg_q.source_mac  <= cfg_data_i;
        uihg_pkg::REG_DEST_MAC:    cfg_q.dest_mac    <= cfg_data_i;
        uihg_pkg::REG_SOURCE_IP:   cfg_q.source_ip   <= cfg_data_i[31:0];
        uihg_pkg::REG_DEST_IP:     cfg_q.dest_ip     <= cfg_data_i[31:0];
        uihg_pkg::REG_SOURCE_PORT: cfg_q.source_port <= cfg_data_i[15:0];
        uihg_pkg::REG_DEST_PORT:   cfg_q.dest_port   <= cfg_data_i[15:0];
        default: begin
        end
      endcase
    end
  end

  uihg_front #(
    .MAX_PAYLOAD(MAX_PAYLOAD)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tlast (s_axis_tlast),
    .q_status_i   (q_status),
    .push_o       (q_push),
    .desc_o       (push_desc)
  );

  uihg_queue #(
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (q_push),
    .push_data_i(push_desc),
    .pop_i      (q_pop),
    .pop_data_o (pop_desc),
    .status_o   (q_status)
  );

  uihg_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .q_status_i   (q_status),
    .q_data_i     (pop_desc),
    .q_pop_o      (q_pop),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast),
    .m_axis_tuser (m_axis_tuser)
  );

  // The closing word carries only the UDP checksum, with two valid bytes.
  `UIHG_ASSERT_NOW(a_last_word_shape, clk_i, rst_ni, m_axis_tvalid && m_axis_tlast, (m_axis_tdata[47:0] == 48'h0) && (m_axis_tdata[67:64] == uihg_pkg::VB_LAST), "final header word malformed")
  // A datagram is never closed into a full queue.
  `UIHG_ASSERT_NOW(a_no_push_full, clk_i, rst_ni, q_push, !q_status.full, "push into full queue")
  // A closed datagram is waiting in the queue in the next cycle.
  `UIHG_ASSERT_NEXT(a_push_visible, clk_i, rst_ni, q_push, !q_status.empty, "pushed datagram lost")

endmodule

`default_nettype wire

FILE: tb/udp_ipv4_header_generator_top_test.sv
`timescale 1ns / 1ps

module udp_ipv4_header_generator_top_test;
  import uihg_pkg::*;

  localparam int unsigned PAYLOAD_LIMIT = MAX_PAYLOAD_DEF;
  localparam int unsigned GAP_PERCENT   = 36;
  localparam int unsigned DRAIN_CYCLES  = 16;
  localparam int unsigned CYCLE_LIMIT   = 200000;
  localparam int unsigned REPORT_LIMIT  = 10;
  localparam int unsigned HDR_WORDS     = 6;
  // Indexes past the last register; writes to them must change nothing.
  localparam logic [2:0] REG_SPARE_LO = 3'd6;
  localparam logic [2:0] REG_SPARE_HI = 3'd7;

  localparam int FILL_RANDOM = -1;
  localparam int MODE_ZERO   = 0;
  localparam int MODE_ONES   = 1;
  localparam int MODE_MIXED  = 2;

  typedef struct packed {
    bit          is_cfg;
    bit          calm;
    logic [2:0]  idx;
    logic [47:0] value;
    logic [7:0]  data;
    logic        last;
  } stim_t;

  typedef struct packed {
    logic [63:0] word;
    logic [3:0]  nbytes;
    logic        last;
    logic        too_long;
  } hdr_word_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = '0;
  logic        s_axis_tlast = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [71:0] m_axis_tdata;
  logic        m_axis_tlast;
  logic        m_axis_tuser;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [2:0]  cfg_index_i = '0;
  logic [47:0] cfg_data_i = '0;

  stim_t     stim_q[$];
  hdr_word_t hdr_expected[$];
  int unsigned items_total = 0;
  int unsigned items_taken = 0;
  int unsigned quiet_cycles = 0;
  int unsigned cycle_count = 0;
  int unsigned errors = 0;
  bit          calm_now = 1'b0;

  // Shadow of the configuration registers.
  logic [47:0] src_mac = '0;
  logic [47:0] dst_mac = '0;
  logic [31:0] src_ip = '0;
  logic [31:0] dst_ip = '0;
  logic [15:0] src_port = '0;
  logic [15:0] dst_port = DEST_PORT_RST;

  // Running state of the datagram being received.
  logic [10:0] pay_count = '0;
  logic [15:0] pay_sum = '0;
  logic [7:0]  hi_byte = '0;
  logic        odd_pos = 1'b0;
  logic        dropped = 1'b0;

  udp_ipv4_header_generator_top u_dut (.*);

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  function automatic logic [15:0] fold_add(input logic [15:0] a, input logic [15:0] b);
    logic [16:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s > 17'h0ffff) s = s - 17'h0ffff;
    return s[15:0];
  endfunction

  task automatic note_error(input string msg);
    errors++;
    if (errors <= REPORT_LIMIT) $display("ERROR: %s", msg);
  endtask

  task automatic apply_reg(input logic [2:0] idx, input logic [47:0] value);
    case (idx)
      REG_SOURCE_MAC:  src_mac = value;
      REG_DEST_MAC:    dst_mac = value;
      REG_SOURCE_IP:   src_ip = value[31:0];
      REG_DEST_IP:     dst_ip = value[31:0];
      REG_SOURCE_PORT: src_port = value[15:0];
      REG_DEST_PORT:   dst_port = value[15:0];
      default: ;
    endcase
  endtask

  // Advances the count and checksum; on the last byte queues the six header words.
  task automatic take_byte(input logic [7:0] b, input logic fin);
    logic [15:0]  udp_len;
    logic [15:0]  ip_len;
    logic [15:0]  udp_sum;
    logic [15:0]  ip_sum;
    logic [383:0] hdr;
    hdr_word_t    w;
    if (pay_count >= PAYLOAD_LIMIT) begin
      dropped = 1'b1;
    end else begin
      pay_count = pay_count + 11'd1;
      if (odd_pos) begin
        pay_sum = fold_add(pay_sum, {hi_byte, b});
        hi_byte = '0;
        odd_pos = 1'b0;
      end else begin
        hi_byte = b;
        odd_pos = 1'b1;
      end
    end
    if (fin) begin
      udp_len = {5'd0, pay_count} + UDP_HDR_BYTES;
      ip_len  = {5'd0, pay_count} + IP_UDP_HDR_BYTES;

      // An odd trailing byte is padded with a zero low byte.
      udp_sum = pay_sum;
      if (odd_pos) udp_sum = fold_add(udp_sum, {hi_byte, 8'h00});
      udp_sum = fold_add(udp_sum, src_ip[31:16]);
      udp_sum = fold_add(udp_sum, src_ip[15:0]);
      udp_sum = fold_add(udp_sum, dst_ip[31:16]);
      udp_sum = fold_add(udp_sum, dst_ip[15:0]);
      udp_sum = fold_add(udp_sum, {8'h00, IP_PROTO_UDP});
      udp_sum = fold_add(udp_sum, udp_len);
      udp_sum = fold_add(udp_sum, src_port);
      udp_sum = fold_add(udp_sum, dst_port);
      udp_sum = fold_add(udp_sum, udp_len);

      ip_sum = fold_add({IP_VER_IHL, IP_TOS}, ip_len);
      ip_sum = fold_add(ip_sum, IP_ID);
      ip_sum = fold_add(ip_sum, {IP_TTL, IP_PROTO_UDP});
      ip_sum = fold_add(ip_sum, src_ip[31:16]);
      ip_sum = fold_add(ip_sum, src_ip[15:0]);
      ip_sum = fold_add(ip_sum, dst_ip[31:16]);
      ip_sum = fold_add(ip_sum, dst_ip[15:0]);

      hdr = {dst_mac, src_mac, ETHERTYPE_IPV4, IP_VER_IHL, IP_TOS, ip_len, IP_ID, IP_FRAG,
             IP_TTL, IP_PROTO_UDP, ~ip_sum, src_ip, dst_ip, src_port, dst_port, udp_len,
             ~udp_sum, 48'd0};
      for (int i = 0; i < HDR_WORDS; i++) begin
        w.word     = hdr[383 - 64 * i -: 64];
        w.last     = (i == HDR_WORDS - 1);
        w.nbytes   = w.last ? VB_LAST : VB_FULL;
        w.too_long = dropped;
        hdr_expected.push_back(w);
      end

      pay_count = '0;
      pay_sum   = '0;
      hi_byte   = '0;
      odd_pos   = 1'b0;
      dropped   = 1'b0;
    end
  endtask

  // Byte and register driver.
  always @(posedge clk_i) begin
    stim_t head;
    logic  byte_held;
    logic  reg_held;
    logic  next_byte;
    logic  next_reg;
    byte_held = s_axis_tvalid && !s_axis_tready;
    reg_held  = cfg_valid_i && !cfg_ready_o;
    next_byte = byte_held;
    next_reg  = reg_held;
    if (rst_ni && !byte_held && !reg_held && stim_q.size() != 0) begin
      head = stim_q[0];
      if (head.is_cfg) begin
        // Registers change only once the block has gone quiet.
        if (quiet_cycles >= DRAIN_CYCLES && !s_axis_tvalid) begin
          cfg_index_i <= head.idx;
          cfg_data_i  <= head.value;
          next_reg = 1'b1;
          void'(stim_q.pop_front());
        end
      end else if (head.calm || $urandom_range(99) >= GAP_PERCENT) begin
        s_axis_tdata <= head.data;
        s_axis_tlast <= head.last;
        calm_now     <= head.calm;
        next_byte = 1'b1;
        void'(stim_q.pop_front());
      end
    end
    s_axis_tvalid <= next_byte;
    cfg_valid_i   <= next_reg;
  end

  always @(posedge clk_i) begin
    m_axis_tready <= rst_ni && (calm_now || $urandom_range(99) >= GAP_PERCENT);
  end

  // Monitor: tracks accepted bytes and register writes and compares header words in order.
  always @(posedge clk_i) begin
    hdr_word_t want;
    if (rst_ni) begin
      if (cfg_valid_i && cfg_ready_o) begin
        apply_reg(cfg_index_i, cfg_data_i);
        items_taken++;
      end
      if (s_axis_tvalid && s_axis_tready) begin
        take_byte(s_axis_tdata, s_axis_tlast);
        items_taken++;
      end
      if (m_axis_tvalid && m_axis_tready) begin
        if (hdr_expected.size() == 0) begin
          note_error($sformatf("header word %h arrived with none expected",
                               m_axis_tdata[63:0]));
        end else begin
          want = hdr_expected.pop_front();
          if (m_axis_tdata[63:0] !== want.word || m_axis_tdata[67:64] !== want.nbytes ||
              m_axis_tlast !== want.last || m_axis_tuser !== want.too_long) begin
            note_error($sformatf(
              "expected word %h bytes %0d last %b too_long %b, got %h bytes %0d last %b too_long %b",
              want.word, want.nbytes, want.last, want.too_long, m_axis_tdata[63:0],
              m_axis_tdata[67:64], m_axis_tlast, m_axis_tuser));
          end
        end
      end
      if (hdr_expected.size() != 0 || s_axis_tvalid || m_axis_tvalid) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles < DRAIN_CYCLES) begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  task automatic add_reg(input logic [2:0] idx, input logic [47:0] value);
    stim_t s;
    s = '0;
    s.is_cfg = 1'b1;
    s.idx    = idx;
    s.value  = value;
    stim_q.push_back(s);
    items_total++;
  endtask

  task automatic add_datagram(input int len, input int fill, input bit calm);
    stim_t s;
    for (int i = 0; i < len; i++) begin
      s = '0;
      s.calm = calm;
      s.data = (fill == FILL_RANDOM) ? 8'($urandom_range(255)) : 8'(fill);
      s.last = (i == len - 1);
      stim_q.push_back(s);
      items_total++;
    end
  endtask

  function automatic logic [47:0] pick_value(input int mode);
    logic [63:0] r;
    r = {$urandom, $urandom};
    if (mode == MODE_ZERO) return '0;
    if (mode == MODE_ONES) return '1;
    case ($urandom_range(3))
      0: return '0;
      1: return '1;
      default: return r[47:0];
    endcase
  endfunction

  task automatic load_regs(input int mode);
    add_reg(REG_SOURCE_MAC, pick_value(mode));
    add_reg(REG_DEST_MAC, pick_value(mode));
    add_reg(REG_SOURCE_IP, pick_value(mode));
    add_reg(REG_DEST_IP, pick_value(mode));
    add_reg(REG_SOURCE_PORT, pick_value(mode));
    add_reg(REG_DEST_PORT, pick_value(mode));
  endtask

  initial begin
    int len;
    int sent;

    // Reset register values, odd and even lengths, extreme byte values.
    add_datagram(1, 8'h00, 1'b0);
    add_datagram(1, 8'hff, 1'b0);
    add_datagram(2, 8'hff, 1'b0);
    add_datagram(2, 8'h00, 1'b0);
    add_datagram(3, 8'hff, 1'b0);
    add_datagram(5, FILL_RANDOM, 1'b0);

    load_regs(MODE_ONES);
    add_reg(REG_SPARE_LO, pick_value(MODE_MIXED));
    add_reg(REG_SPARE_HI, '1);
    add_datagram(2, 8'hff, 1'b0);
    add_datagram(1, 8'h80, 1'b0);
    add_datagram(4, FILL_RANDOM, 1'b0);

    load_regs(MODE_ZERO);
    add_datagram(1, 8'h00, 1'b0);
    add_datagram(2, 8'h00, 1'b0);

    for (int phase = 0; phase < 6; phase++) begin
      load_regs(MODE_MIXED);
      if ($urandom_range(2) == 0) add_reg(REG_SPARE_LO, pick_value(MODE_MIXED));
      sent = 0;
      while (sent < 14) begin
        len = ($urandom_range(99) < 80) ? $urandom_range(1, 8) : $urandom_range(9, 40);
        add_datagram(len, FILL_RANDOM, phase == 3);
        sent += len;
      end
    end

    do @(posedge clk_i);
    while (items_taken != items_total || hdr_expected.size() != 0 ||
           quiet_cycles < DRAIN_CYCLES);

    if (errors == 0 && hdr_expected.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
